// File: rtl/core/assert_macros.svh
// Assertion macros for the scanner RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Clocked check, skipped while reset is asserted.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// File: rtl/core/wbps_pkg.sv
// Shared constants and a helper function for the wildcard byte pattern scanner.
`default_nettype none

package wbps_pkg;

  localparam int unsigned MAX_PATTERN_BYTES = 32;
  localparam int unsigned BYTE_W            = 8;
  localparam int unsigned WIN_W             = MAX_PATTERN_BYTES * BYTE_W;
  localparam int unsigned LEN_W             = 6;
  localparam int unsigned SHIFT_W           = $clog2(MAX_PATTERN_BYTES);
  localparam int unsigned ADDR_W            = 32;
  localparam int unsigned CFG_IDX_W         = 3;
  localparam int unsigned CFG_DATA_W        = 64;
  localparam int unsigned PAT_REGS          = 4;
  localparam int unsigned PAT_W             = PAT_REGS * CFG_DATA_W;

  localparam logic [BYTE_W-1:0] WILDCARD_BYTE = 8'h2f;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PAT_0_7   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_8_15  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_16_23 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_24_31 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BASE      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET    = 3'd6;

  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PATTERN_BYTES);
  localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);

  // Zero acts as one, anything above the window depth acts as the depth.
  function automatic logic [LEN_W-1:0] active_len(input logic [LEN_W-1:0] raw);
    logic [LEN_W-1:0] len;
    len = raw;
    if (raw == '0) begin
      len = LEN_ONE;
    end else if (raw > LEN_MAX) begin
      len = LEN_MAX;
    end
    return len;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/wbps_match.sv
// Parallel wildcard compare of the byte window against the pattern.
`default_nettype none

module wbps_match (
  input  wire logic [wbps_pkg::WIN_W-1:0] window_i,  // newest byte in the low bits
  input  wire logic [wbps_pkg::PAT_W-1:0] pattern_i, // pattern byte 0 in the low bits
  input  wire logic [wbps_pkg::LEN_W-1:0] len_i,     // active length, 1 to depth
  output logic                            hit_o
);

  logic [wbps_pkg::WIN_W-1:0]   rev_win;
  logic [wbps_pkg::WIN_W-1:0]   aligned;
  logic [wbps_pkg::LEN_W-1:0]   shift_full;
  logic [wbps_pkg::SHIFT_W-1:0] shift_amt;
  logic [wbps_pkg::MAX_PATTERN_BYTES-1:0] byte_ok;

  // Oldest byte goes to the low end, then drop the bytes older than the pattern.
  always_comb begin
    for (int j = 0; j < wbps_pkg::MAX_PATTERN_BYTES; j++) begin
      rev_win[j*wbps_pkg::BYTE_W +: wbps_pkg::BYTE_W] =
        window_i[(wbps_pkg::MAX_PATTERN_BYTES-1-j)*wbps_pkg::BYTE_W +: wbps_pkg::BYTE_W];
    end
  end

  assign shift_full = wbps_pkg::LEN_MAX - len_i;
  assign shift_amt  = shift_full[wbps_pkg::SHIFT_W-1:0];
  assign aligned    = rev_win >> {shift_amt, 3'b000};

  for (genvar x = 0; x < wbps_pkg::MAX_PATTERN_BYTES; x++) begin : g_cmp
    logic [wbps_pkg::BYTE_W-1:0] pat_b;
    logic [wbps_pkg::BYTE_W-1:0] win_b;
    assign pat_b = pattern_i[x*wbps_pkg::BYTE_W +: wbps_pkg::BYTE_W];
    assign win_b = aligned[x*wbps_pkg::BYTE_W +: wbps_pkg::BYTE_W];
    assign byte_ok[x] = (wbps_pkg::LEN_W'(x) >= len_i) ||
                        (pat_b == wbps_pkg::WILDCARD_BYTE) ||
                        (pat_b == win_b);
  end

  assign hit_o = &byte_ok;

endmodule

`default_nettype wire

// File: rtl/core/wildcard_byte_pattern_scanner_unit.sv
// Top level of the wildcard byte pattern scanner.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------
//  in      | sink      | in_valid/in_stall  | data_byte, last_byte
//  out     | source    | out_valid/out_stall| found, match_address
//  cfg     | sink      | cfg_valid/ready    | cfg_index, cfg_data
//
// One byte per cycle sustained while no output stall holds the flow; each byte
// waits in the input register, then the window compare and address add load the
// result register.
// Reset clears control state and the configuration; the window is not cleared,
// the fill count gates the compare instead.
// An output stall holds the result register and backs up into the input register.
`default_nettype none

module wildcard_byte_pattern_scanner_unit (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [wbps_pkg::BYTE_W-1:0]         data_byte_i,
  input  wire logic                                last_byte_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic                                     found_o,
  output logic [wbps_pkg::ADDR_W-1:0]              match_address_o,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [wbps_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [wbps_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

`include "assert_macros.svh"

  // Configuration
  logic [wbps_pkg::PAT_W-1:0]  pattern_q;
  logic [wbps_pkg::LEN_W-1:0]  pat_len_q;
  logic [wbps_pkg::ADDR_W-1:0] base_q;
  logic [wbps_pkg::ADDR_W-1:0] offset_q;
  logic                        cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= '0;
      pat_len_q <= wbps_pkg::LEN_ONE;
      base_q    <= '0;
      offset_q  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        wbps_pkg::REG_PAT_0_7,
        wbps_pkg::REG_PAT_8_15,
        wbps_pkg::REG_PAT_16_23,
        wbps_pkg::REG_PAT_24_31:
          pattern_q[cfg_index_i[1:0]*wbps_pkg::CFG_DATA_W +: wbps_pkg::CFG_DATA_W] <=
            cfg_data_i;
        wbps_pkg::REG_PAT_LEN: pat_len_q <= cfg_data_i[wbps_pkg::LEN_W-1:0];
        wbps_pkg::REG_BASE:    base_q    <= cfg_data_i[wbps_pkg::ADDR_W-1:0];
        wbps_pkg::REG_OFFSET:  offset_q  <= cfg_data_i[wbps_pkg::ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  logic                        s1_valid_q;
  logic [wbps_pkg::BYTE_W-1:0] s1_byte_q;
  logic                        s1_last_q;
  logic                        in_xfer;
  logic                        advance;

  logic                        out_valid_q;
  logic                        found_q;
  logic [wbps_pkg::ADDR_W-1:0] addr_q;

  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && out_valid_q && out_stall_i;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_byte_q <= data_byte_i;
      s1_last_q <= last_byte_i;
    end
  end

  // Stream state
  logic [wbps_pkg::WIN_W-1:0]  window_q;
  logic [wbps_pkg::WIN_W-1:0]  window_d;
  logic [wbps_pkg::LEN_W-1:0]  fill_q;
  logic [wbps_pkg::LEN_W-1:0]  fill_d;
  logic [wbps_pkg::ADDR_W-1:0] pos_q;
  logic                        reported_q;
  logic [wbps_pkg::LEN_W-1:0]  len;
  logic                        win_hit;
  logic                        hit;
  logic                        not_found;
  logic [wbps_pkg::ADDR_W-1:0] hit_addr;

  assign len      = wbps_pkg::active_len(pat_len_q);
  assign window_d = {window_q[wbps_pkg::WIN_W-wbps_pkg::BYTE_W-1:0], s1_byte_q};
  assign fill_d   = (fill_q == wbps_pkg::LEN_MAX) ? fill_q : fill_q + wbps_pkg::LEN_ONE;

  wbps_match u_match (
    .window_i  (window_d),
    .pattern_i (pattern_q),
    .len_i     (len),
    .hit_o     (win_hit)
  );

  assign hit       = !reported_q && (fill_d >= len) && win_hit;
  assign not_found = s1_last_q && !reported_q && !hit;
  // Start of the window is pos + 1 - len.
  assign hit_addr  = base_q + offset_q + pos_q + wbps_pkg::ADDR_W'(1)
                     - wbps_pkg::ADDR_W'(len);

  always_ff @(posedge clk_i) begin
    if (advance) begin
      window_q <= window_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      pos_q      <= '0;
      reported_q <= 1'b0;
    end else if (advance) begin
      if (s1_last_q) begin
        // End of image: clear for the next one.
        fill_q     <= '0;
        pos_q      <= '0;
        reported_q <= 1'b0;
      end else begin
        fill_q     <= fill_d;
        pos_q      <= pos_q + wbps_pkg::ADDR_W'(1);
        reported_q <= reported_q || hit;
      end
    end
  end

  // Result register
  logic out_load;

  assign out_load = advance && (hit || not_found);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      found_q <= hit;
      addr_q  <= hit ? hit_addr : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign found_o         = found_q;
  assign match_address_o = addr_q;

  `ASSERT_RST(a_notfound_addr_zero, clk_i, rst_ni, out_valid_q && !found_q |-> addr_q == '0, "not-found result carries a nonzero address")
  `ASSERT_RST(a_hit_sets_reported, clk_i, rst_ni, out_load && hit && !s1_last_q |=> reported_q, "match not recorded")
  `ASSERT_RST(a_no_second_result, clk_i, rst_ni, advance && reported_q |-> !out_load, "result after a match in the same image")
  `ASSERT_ALWAYS(a_fill_bound, clk_i, fill_q <= wbps_pkg::LEN_MAX, "fill count past window depth")

endmodule

`default_nettype wire

// File: tb/tb_wildcard_byte_pattern_scanner_unit.sv
// Testbench for the wildcard byte pattern scanner: match predictor, scoreboard and stimulus.
module tb_wildcard_byte_pattern_scanner_unit;
  import wbps_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int unsigned ITEM_TARGET   = 925;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned CYCLE_LIMIT   = 500000;
  localparam int unsigned REPORT_LIMIT  = 10;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] address;
  } scan_report_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } image_byte_t;

  class scan_scoreboard;
    logic [CFG_DATA_W-1:0] pat_reg [PAT_REGS];
    logic [LEN_W-1:0]      len_raw;
    logic [ADDR_W-1:0]     base_addr;
    logic [ADDR_W-1:0]     addr_offset;
    logic [BYTE_W-1:0]     history [MAX_PATTERN_BYTES];
    logic [ADDR_W-1:0]     position;
    bit                    reported;
    int unsigned           fill;
    scan_report_t          expected_reports[$];
    int unsigned           errors;

    function new();
      foreach (pat_reg[j]) pat_reg[j] = '0;
      len_raw = LEN_W'(1);
      base_addr = '0;
      addr_offset = '0;
      errors = 0;
      clear_image();
    endfunction

    function void clear_image();
      foreach (history[k]) history[k] = '0;
      position = '0;
      reported = 1'b0;
      fill = 0;
    endfunction

    function int unsigned active_len();
      if (len_raw == '0) return 1;
      if (len_raw > MAX_PATTERN_BYTES) return MAX_PATTERN_BYTES;
      return len_raw;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_PAT_0_7, REG_PAT_8_15, REG_PAT_16_23, REG_PAT_24_31: pat_reg[idx] = val;
        REG_PAT_LEN: len_raw = val[LEN_W-1:0];
        REG_BASE:    base_addr = val[ADDR_W-1:0];
        REG_OFFSET:  addr_offset = val[ADDR_W-1:0];
        default: ;
      endcase
    endfunction

    // history[k] is the byte received k transfers ago
    function bit window_hit(int unsigned len);
      logic [BYTE_W-1:0] p;
      for (int unsigned x = 0; x < len; x++) begin
        p = pat_reg[x / 8][(x % 8) * 8 +: 8];
        if (p != WILDCARD_BYTE && p != history[len - 1 - x]) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void take_byte(logic [BYTE_W-1:0] d, logic last);
      int unsigned  len;
      scan_report_t rep;
      len = active_len();
      for (int k = MAX_PATTERN_BYTES - 1; k > 0; k--) history[k] = history[k - 1];
      history[0] = d;
      if (fill < MAX_PATTERN_BYTES) fill++;
      if (!reported && fill >= len && window_hit(len)) begin
        rep.found = 1'b1;
        rep.address = base_addr + (position + ADDR_W'(1) - ADDR_W'(len)) + addr_offset;
        expected_reports.push_back(rep);
        reported = 1'b1;
      end
      position++;
      if (last) begin
        if (!reported) begin
          rep.found = 1'b0;
          rep.address = '0;
          expected_reports.push_back(rep);
        end
        clear_image();
      end
    endfunction

    function void check_report(logic found, logic [ADDR_W-1:0] address);
      scan_report_t exp_rep;
      if (expected_reports.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("unexpected result: found=%0b match_address=%h", found, address);
        return;
      end
      exp_rep = expected_reports.pop_front();
      if (exp_rep.found !== found || exp_rep.address !== address) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display({"result mismatch: expected found=%0b match_address=%h,",
                    " got found=%0b match_address=%h"},
                   exp_rep.found, exp_rep.address, found, address);
      end
    endfunction

    function void close_out();
      if (expected_reports.size() != 0) begin
        errors += expected_reports.size();
        $display("%0d expected results never arrived", expected_reports.size());
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [BYTE_W-1:0]     data_byte_i;
  logic                  last_byte_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic                  found_o;
  logic [ADDR_W-1:0]     match_address_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  scan_scoreboard sb;
  logic [BYTE_W-1:0] cur_pattern [MAX_PATTERN_BYTES];
  image_byte_t       image_q[$];
  image_byte_t       carry_q[$];
  int unsigned       bytes_sent = 0;
  int unsigned       cycle_count = 0;
  int unsigned       stall_hold = 0;
  bit                gaps_on;
  logic              stall_on = 1'b0;

  wildcard_byte_pattern_scanner_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .found_o        (found_o),
    .match_address_o(match_address_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_wildcard_byte_pattern_scanner_unit: FAIL");
      $finish;
    end
  end

  function automatic int unsigned pick_run();
    if ($urandom_range(0, 99) < 85) return $urandom_range(0, 2);
    return $urandom_range(3, 24);
  endfunction

  // Receiver: hold stall high or low for random runs
  always @(posedge clk_i) begin
    if (!stall_on) begin
      out_stall_i <= 1'b0;
    end else if (stall_hold != 0) begin
      stall_hold--;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < 40);
      stall_hold = pick_run();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0)
      sb.check_report(found_o, match_address_o);
  end

  function automatic int unsigned pick_gap();
    if (!gaps_on || $urandom_range(0, 99) < 60) return 0;
    return pick_run();
  endfunction

  function automatic logic [BYTE_W-1:0] noise_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return BYTE_W'($urandom_range(8'h41, 8'h43));
    if (r < 50) return '0;
    if (r < 55) return '1;
    if (r < 60) return WILDCARD_BYTE;
    return BYTE_W'($urandom);
  endfunction

  function automatic logic [BYTE_W-1:0] pattern_pick();
    if ($urandom_range(0, 99) < 25) return WILDCARD_BYTE;
    return noise_byte();
  endfunction

  function automatic logic [LEN_W-1:0] pick_len_raw();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return LEN_MAX;
    if (r < 27) return LEN_W'($urandom_range(33, 63));
    if (r < 40) return LEN_W'($urandom_range(9, 31));
    return LEN_W'($urandom_range(1, 8));
  endfunction

  function automatic logic [ADDR_W-1:0] pick_addr();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 30) return '1;
    return ADDR_W'($urandom);
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] d, input logic l);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      data_byte_i <= BYTE_W'($urandom);
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= d;
    last_byte_i <= l;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sb.take_byte(d, l);
    bytes_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    sb.set_reg(idx, val);
  endtask

  // Hold the sender until every expected result is back and the pipe is empty
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.expected_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic reprogram(input bit all_regs);
    logic [CFG_DATA_W-1:0] word;
    int                    j;
    int                    i;
    for (j = 0; j < PAT_REGS; j++) begin
      if (all_regs || $urandom_range(0, 4) != 0) begin
        for (i = 0; i < 8; i++) begin
          cur_pattern[8 * j + i] = pattern_pick();
          word[8 * i +: 8] = cur_pattern[8 * j + i];
        end
        write_reg(CFG_IDX_W'(REG_PAT_0_7 + j), word);
      end
    end
    if (all_regs || $urandom_range(0, 4) != 0) begin
      word = {$urandom, $urandom};
      word[LEN_W-1:0] = pick_len_raw();
      write_reg(REG_PAT_LEN, word);
    end
    if (all_regs || $urandom_range(0, 4) != 0) write_reg(REG_BASE, {$urandom, pick_addr()});
    if (all_regs || $urandom_range(0, 4) != 0) write_reg(REG_OFFSET, {$urandom, pick_addr()});
    if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, {$urandom, $urandom});
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly planted pattern instances, some with one corrupted byte, the rest noise
  task automatic build_image();
    int unsigned       len;
    int                r;
    int                flip;
    int                x;
    logic [BYTE_W-1:0] b;
    image_q.delete();
    len = sb.active_len();
    r = $urandom_range(0, 99);
    if (r < 80) begin
      repeat (($urandom_range(0, 9) < 8) ? $urandom_range(0, 6) : $urandom_range(7, 40))
        image_q.push_back({noise_byte(), 1'b0});
      flip = (r >= 65) ? int'($urandom_range(0, len - 1)) : -1;
      for (x = 0; x < len; x++) begin
        b = (cur_pattern[x] == WILDCARD_BYTE) ? noise_byte() : cur_pattern[x];
        if (x == flip) b = b ^ (BYTE_W'(1) << $urandom_range(0, 7));
        image_q.push_back({b, 1'b0});
      end
      repeat ($urandom_range(0, 1) ? 0 : $urandom_range(1, 6))
        image_q.push_back({noise_byte(), 1'b0});
    end else begin
      repeat ($urandom_range(1, 24)) image_q.push_back({noise_byte(), 1'b0});
    end
    image_q[image_q.size() - 1].last = 1'b1;
  endtask

  task automatic flush_carry();
    image_byte_t e;
    while (carry_q.size() != 0) begin
      e = carry_q.pop_front();
      send_byte(e.data, e.last);
    end
  endtask

  initial begin
    int unsigned n_img;
    int unsigned cut;
    int unsigned i;
    int unsigned k;
    sb = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    data_byte_i = '0;
    last_byte_i = 1'b0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    gaps_on = 1'b1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    stall_on <= 1'b1;

    // Reset configuration: pattern byte zero, length one; match on the last byte
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b1);
    send_byte(8'hff, 1'b1);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b1);
    drain();

    // Wildcard in front, window not yet full, address sum wraps
    write_reg(REG_PAT_0_7, 64'hffff_ffff_2211_002f);
    write_reg(REG_PAT_8_15, '1);
    write_reg(REG_PAT_16_23, '0);
    write_reg(REG_PAT_24_31, {8{WILDCARD_BYTE}});
    write_reg(REG_PAT_LEN, 64'd4);
    write_reg(REG_BASE, 64'hffff_fff0);
    write_reg(REG_OFFSET, 64'hffff_ffff);
    write_reg(REG_UNUSED, '1);
    cfg_valid_i <= 1'b0;
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b1);
    send_byte(8'h7f, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'h55, 1'b1);
    drain();

    // Length zero acts as one, single wildcard matches anything
    write_reg(REG_PAT_LEN, 64'hffff_ffff_ffff_ffc0);
    write_reg(REG_PAT_0_7, {56'd0, WILDCARD_BYTE});
    write_reg(REG_BASE, '0);
    write_reg(REG_OFFSET, 64'h8000_0000);
    cfg_valid_i <= 1'b0;
    send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b1);
    drain();

    reprogram(1'b1);
    while (bytes_sent < ITEM_TARGET) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      stall_on <= ($urandom_range(0, 3) != 0);
      flush_carry();
      n_img = $urandom_range(2, 6);
      for (i = 0; i < n_img; i++) begin
        build_image();
        cut = image_q.size();
        // Leave the last image open across the next register writes
        if (i == n_img - 1 && cut > 1 && $urandom_range(0, 3) == 0)
          cut = $urandom_range(1, cut - 1);
        for (k = 0; k < image_q.size(); k++) begin
          if (k < cut) send_byte(image_q[k].data, image_q[k].last);
          else carry_q.push_back(image_q[k]);
        end
        if ($urandom_range(0, 9) == 0) drain();
      end
      drain();
      reprogram(1'b0);
    end
    flush_carry();
    drain();

    sb.close_out();
    if (sb.errors == 0) begin
      $display("tb_wildcard_byte_pattern_scanner_unit: PASS");
    end else begin
      $display("tb_wildcard_byte_pattern_scanner_unit: FAIL");
    end
    $finish;
  end

endmodule

// File: wildcard_byte_pattern_scanner_unit.f
+incdir+rtl/core
rtl/core/wbps_pkg.sv
rtl/core/wbps_match.sv
rtl/core/wildcard_byte_pattern_scanner_unit.sv
tb/tb_wildcard_byte_pattern_scanner_unit.sv
